### rtl/core/malu_pkg.sv
// ----------------------------------------------------------------------------
// malu_pkg
// shared types, constants and table functions of the angle lattice update
// ----------------------------------------------------------------------------
package malu_pkg;

  localparam int SIDE   = 64;
  localparam int COORD_W = $clog2(SIDE);
  localparam int ADDR_W  = 2 * COORD_W;
  localparam int DEPTH   = SIDE * SIDE;

  localparam logic [1:0] REG_COUPLING = 2'd0;
  localparam logic [1:0] REG_FIELD    = 2'd1;
  localparam logic [1:0] REG_INV_TEMP = 2'd2;

  localparam logic [15:0] COUPLING_RST = 16'd4096;
  localparam logic [15:0] FIELD_RST    = 16'd0;
  localparam logic [15:0] INV_TEMP_RST = 16'd512;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [2:0] RD_SITE  = 3'd0;
  localparam logic [2:0] RD_DOWN  = 3'd1;
  localparam logic [2:0] RD_UP    = 3'd2;
  localparam logic [2:0] RD_RIGHT = 3'd3;
  localparam logic [2:0] RD_LEFT  = 3'd4;

  localparam logic [3:0] OP_CS_NEW = 4'd8;
  localparam logic [3:0] OP_LAST   = 4'd9;

  localparam logic [16:0] LN2_INV = 17'd94548;

  typedef struct packed {
    logic       latch;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       cap_en;
    logic [2:0] cap_sel;
    logic       cos_en;
    logic [3:0] cos_idx;
    logic       sq_en;
    logic [3:0] sq_idx;
    logic       emul;
    logic       scale;
    logic       exp1;
    logic       exp2;
    logic       exp3;
    logic       exp4;
    logic       fin_upd;
    logic       fin_load;
  } malu_cmd_t;

  typedef struct packed {
    logic is_update;
    logic out_free;
  } malu_sts_t;

  function automatic logic [14:0] cos_tab(input logic [4:0] i);
    logic [14:0] v;
    case (i)
      5'd0:    v = 15'd16384;
      5'd1:    v = 15'd16305;
      5'd2:    v = 15'd16069;
      5'd3:    v = 15'd15679;
      5'd4:    v = 15'd15137;
      5'd5:    v = 15'd14449;
      5'd6:    v = 15'd13623;
      5'd7:    v = 15'd12665;
      5'd8:    v = 15'd11585;
      5'd9:    v = 15'd10394;
      5'd10:   v = 15'd9102;
      5'd11:   v = 15'd7723;
      5'd12:   v = 15'd6270;
      5'd13:   v = 15'd4756;
      5'd14:   v = 15'd3196;
      5'd15:   v = 15'd1606;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] pow2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44377;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34218;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

  function automatic logic [14:0] quarter_cos(input logic [14:0] r);
    logic [14:0] a;
    logic [14:0] b;
    logic [14:0] d;
    logic [25:0] prod;
    logic [14:0] v;
    a    = cos_tab(r[14:10]);
    b    = cos_tab(r[14:10] + 5'd1);
    d    = a - b;
    prod = {1'b0, d} * {15'd0, r[9:0]} + 26'd512;
    v    = a - prod[24:10];
    if (r[14]) begin
      v = 15'd0;
    end
    return v;
  endfunction

  function automatic logic signed [15:0] angle_cos(input logic [15:0] ang);
    logic [14:0] rr;
    logic [14:0] m;
    logic signed [15:0] v;
    rr = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    m  = quarter_cos(rr);
    v  = (ang[15] ^ ang[14]) ? -$signed({1'b0, m}) : $signed({1'b0, m});
    return v;
  endfunction

endpackage

### rtl/core/malu_ctrl.sv
// ----------------------------------------------------------------------------
// malu_ctrl
// sequencer for load and metropolis update requests
// ----------------------------------------------------------------------------
module malu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  malu_pkg::malu_sts_t sts_i,
  output malu_pkg::malu_cmd_t cmd_o
);
  import malu_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_RD, ST_COS, ST_EMUL, ST_SCALE,
    ST_EXP1, ST_EXP2, ST_EXP3, ST_EXP4, ST_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.latch = in_valid_i;
        cnt_d       = 4'd0;
        if (in_valid_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts_i.is_update) begin
          state_d = ST_RD;
        end else if (sts_i.out_free) begin
          cmd_o.fin_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd_o.rd_en   = (cnt_q < 4'd5);
        cmd_o.rd_sel  = cnt_q[2:0];
        cmd_o.cap_en  = (cnt_q != 4'd0);
        cmd_o.cap_sel = cnt_q[2:0] - 3'd1;
        cnt_d         = cnt_q + 4'd1;
        if (cnt_q == 4'd5) begin
          cnt_d   = 4'd0;
          state_d = ST_COS;
        end
      end
      ST_COS: begin
        cmd_o.cos_en  = (cnt_q <= OP_LAST);
        cmd_o.cos_idx = cnt_q;
        cmd_o.sq_en   = (cnt_q != 4'd0);
        cmd_o.sq_idx  = cnt_q - 4'd1;
        cnt_d         = cnt_q + 4'd1;
        if (cnt_q == OP_LAST + 4'd1) begin
          cnt_d   = 4'd0;
          state_d = ST_EMUL;
        end
      end
      ST_EMUL: begin
        cmd_o.emul = 1'b1;
        state_d    = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_EXP1;
      end
      ST_EXP1: begin
        cmd_o.exp1 = 1'b1;
        state_d    = ST_EXP2;
      end
      ST_EXP2: begin
        cmd_o.exp2 = 1'b1;
        state_d    = ST_EXP3;
      end
      ST_EXP3: begin
        cmd_o.exp3 = 1'b1;
        state_d    = ST_EXP4;
      end
      ST_EXP4: begin
        cmd_o.exp4 = 1'b1;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin_upd = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 4'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### rtl/core/malu_dp.sv
// ----------------------------------------------------------------------------
// malu_dp
// lattice memory, cosine and energy arithmetic, acceptance test, result register
// ----------------------------------------------------------------------------
module malu_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  malu_pkg::malu_cmd_t cmd_i,
  output malu_pkg::malu_sts_t sts_o,
  input  logic                command_i,
  input  logic [5:0]          row_i,
  input  logic [5:0]          col_i,
  input  logic [15:0]         load_angle_i,
  input  logic signed [13:0]  angle_step_i,
  input  logic [15:0]         uniform_draw_i,
  input  logic signed [15:0]  coupling_i,
  input  logic signed [15:0]  field_i,
  input  logic [15:0]         inv_temp_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                accepted_o,
  output logic [15:0]         site_angle_o,
  output logic signed [19:0]  energy_change_o
);
  import malu_pkg::*;

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  logic               cmd_q;
  logic [COORD_W-1:0] row_q, col_q;
  logic [15:0]        load_q;
  logic signed [13:0] step_q;
  logic [15:0]        draw_q;

  logic [15:0] old_q, nw_q;
  logic [15:0] nb_q [4];

  logic signed [15:0] c_q;
  logic signed [19:0] tsum_q;
  logic signed [17:0] csd_q;
  logic signed [35:0] pj_q;
  logic signed [33:0] ph_q;
  logic signed [19:0] de_q;
  logic [34:0]        x_q;
  logic [35:0]        yh_q;
  logic [32:0]        yl_q;
  logic [36:0]        y_q;
  logic               big_q;
  logic [3:0]         n_q;
  logic [16:0]        m_q;

  logic               out_valid_q;
  logic               acc_q;
  logic [15:0]        angle_q;
  logic signed [19:0] energy_q;

  logic [COORD_W-1:0] ra, ca;
  logic [ADDR_W-1:0]  raddr, waddr;
  logic               we;
  logic [15:0]        wdata;
  logic [15:0]        opnd;
  logic [31:0]        sq;
  logic [28:0]        sq_r;
  logic signed [17:0] tval;
  logic signed [37:0] ev;
  logic signed [22:0] er;
  logic signed [19:0] de_sat;
  logic [16:0]        pa, pb, pd;
  logic [32:0]        pprod;
  logic [16:0]        pm;
  logic [16:0]        prob;
  logic               acc;

  always_comb begin
    ra = row_q;
    ca = col_q;
    case (cmd_i.rd_sel)
      RD_SITE:  ra = row_q;
      RD_DOWN:  ra = row_q + 1'b1;
      RD_UP:    ra = row_q - 1'b1;
      RD_RIGHT: ca = col_q + 1'b1;
      RD_LEFT:  ca = col_q - 1'b1;
      default:  ra = row_q;
    endcase
    raddr = {ra, ca};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_comb begin
    if (cmd_i.cos_idx == OP_CS_NEW) begin
      opnd = nw_q;
    end else if (cmd_i.cos_idx == OP_LAST) begin
      opnd = old_q;
    end else begin
      opnd = (cmd_i.cos_idx[0] ? old_q : nw_q) - nb_q[cmd_i.cos_idx[2:1]];
    end
  end

  always_comb begin
    sq   = $unsigned(32'(c_q) * 32'(c_q));
    sq_r = sq[28:0] + 29'd8192;
    tval = $signed({1'b0, 2'b00, sq_r[28:14]}) * 18'sd3 - 18'sd16384;
  end

  always_comb begin
    ev = 38'(pj_q) - (38'(ph_q) <<< 3);
    ev = ev + 38'sd16384;
    er = 23'(ev >>> 15);
    if (er > 23'sd524287) begin
      de_sat = 20'sd524287;
    end else if (er < -23'sd524288) begin
      de_sat = -20'sd524288;
    end else begin
      de_sat = er[19:0];
    end
  end

  always_comb begin
    pa    = pow2_tab({1'b0, y_q[19:16]});
    pb    = pow2_tab({1'b0, y_q[19:16]} + 5'd1);
    pd    = pa - pb;
    pprod = pd[15:0] * {1'b0, y_q[15:0]} + 33'd32768;
    pm    = pa - pprod[32:16];
    prob  = big_q ? 17'd0 : (m_q >> n_q);
    acc   = de_q[19] || ({1'b0, draw_q} < prob);
  end

  always_comb begin
    we    = cmd_i.fin_load || (cmd_i.fin_upd && acc);
    waddr = {row_q, col_q};
    wdata = cmd_i.fin_load ? load_q : nw_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      row_q  <= row_i[COORD_W-1:0];
      col_q  <= col_i[COORD_W-1:0];
      load_q <= load_angle_i;
      step_q <= angle_step_i;
      draw_q <= uniform_draw_i;
      tsum_q <= '0;
      csd_q  <= '0;
    end
    if (cmd_i.cap_en) begin
      if (cmd_i.cap_sel == RD_SITE) begin
        old_q <= rdata_q;
        nw_q  <= rdata_q + 16'($signed(step_q));
      end else begin
        nb_q[2'(cmd_i.cap_sel - 3'd1)] <= rdata_q;
      end
    end
    if (cmd_i.cos_en) begin
      c_q <= angle_cos(opnd);
    end
    if (cmd_i.sq_en) begin
      if (cmd_i.sq_idx < OP_CS_NEW) begin
        tsum_q <= cmd_i.sq_idx[0] ? tsum_q - 20'(tval) : tsum_q + 20'(tval);
      end else begin
        csd_q <= cmd_i.sq_idx[0] ? csd_q - 18'(c_q) : csd_q + 18'(c_q);
      end
    end
    if (cmd_i.emul) begin
      pj_q <= coupling_i * tsum_q;
      ph_q <= field_i * csd_q;
    end
    if (cmd_i.scale) begin
      de_q <= de_sat;
    end
    if (cmd_i.exp1) begin
      x_q <= de_q[18:0] * inv_temp_i;
    end
    if (cmd_i.exp2) begin
      yh_q <= x_q[34:16] * LN2_INV;
      yl_q <= x_q[15:0] * LN2_INV;
    end
    if (cmd_i.exp3) begin
      y_q <= 37'(yh_q) + 37'(yl_q[32:16]);
    end
    if (cmd_i.exp4) begin
      big_q <= |y_q[36:24];
      n_q   <= y_q[23:20];
      m_q   <= pm;
    end
    if (cmd_i.fin_load) begin
      acc_q    <= 1'b1;
      angle_q  <= load_q;
      energy_q <= '0;
    end else if (cmd_i.fin_upd) begin
      acc_q    <= acc;
      angle_q  <= acc ? nw_q : old_q;
      energy_q <= de_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cmd_q       <= CMD_LOAD;
    end else begin
      if (cmd_i.latch) begin
        cmd_q <= command_i;
      end
      if (cmd_i.fin_load || cmd_i.fin_upd) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.is_update  = (cmd_q == CMD_UPDATE);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign accepted_o       = acc_q;
  assign site_angle_o     = angle_q;
  assign energy_change_o  = energy_q;

endmodule

### rtl/core/metropolis_angle_lattice_update.sv
// ----------------------------------------------------------------------------
// metropolis_angle_lattice_update
// periodic 64x64 angle lattice with load and metropolis update requests
//
//   port       direction  handshake                  payload
//   in         in         in_valid_i / in_stall_o    command, row, col, load_angle,
//                                                    angle_step, uniform_draw
//   out        out        out_valid_o / out_stall_i  accepted, site_angle,
//                                                    energy_change
//   config     in         apb psel/penable/pready    coupling, field, inverse temp
//
// an update runs five reads on the single lattice read port, ten cosine
// evaluations through one shared cosine/square pipe, then the energy and
// exponential steps. one request is in work at a time. a finished result
// waits in the output register; the next request is taken meanwhile and only
// its final write waits while the output is stalled. reset clears control
// and config; lattice contents are undefined until loaded.
// ----------------------------------------------------------------------------
module metropolis_angle_lattice_update (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [5:0]         row_i,
  input  logic [5:0]         col_i,
  input  logic [15:0]        load_angle_i,
  input  logic signed [13:0] angle_step_i,
  input  logic [15:0]        uniform_draw_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic [15:0]        site_angle_o,
  output logic signed [19:0] energy_change_o
);
  import malu_pkg::*;

  logic [15:0] coupling_q, field_q, inv_temp_q;
  malu_cmd_t   cmd;
  malu_sts_t   sts;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coupling_q <= COUPLING_RST;
      field_q    <= FIELD_RST;
      inv_temp_q <= INV_TEMP_RST;
    end else if (wr) begin
      case (paddr[3:2])
        REG_COUPLING: coupling_q <= pwdata[15:0];
        REG_FIELD:    field_q    <= pwdata[15:0];
        REG_INV_TEMP: inv_temp_q <= pwdata[15:0];
        default:      coupling_q <= coupling_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COUPLING: prdata = {{16{coupling_q[15]}}, coupling_q};
      REG_FIELD:    prdata = {{16{field_q[15]}}, field_q};
      REG_INV_TEMP: prdata = {16'd0, inv_temp_q};
      default:      prdata = 32'd0;
    endcase
  end

  malu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  malu_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .command_i       (command_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .load_angle_i    (load_angle_i),
    .angle_step_i    (angle_step_i),
    .uniform_draw_i  (uniform_draw_i),
    .coupling_i      ($signed(coupling_q)),
    .field_i         ($signed(field_q)),
    .inv_temp_i      (inv_temp_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .accepted_o      (accepted_o),
    .site_angle_o    (site_angle_o),
    .energy_change_o (energy_change_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted without going busy");

  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin_load |=> out_valid_o && accepted_o && (energy_change_o == 20'sd0))
    else $error("load result malformed");

  a_downhill_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin_upd |=> out_valid_o && (!energy_change_o[19] || accepted_o))
    else $error("negative energy change rejected");

  a_fin_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.fin_upd || cmd.fin_load) |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule
